[hw/rtl/code_list_write_interpreter_unit_assert.svh]
// Assertion macros shared by the code list write interpreter RTL.
`ifndef CODE_LIST_WRITE_INTERPRETER_UNIT_ASSERT_SVH
`define CODE_LIST_WRITE_INTERPRETER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on i_clk outside of reset.
`define CLIU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cliu assertion failed");

// Next-cycle implication, checked on i_clk outside of reset.
`define CLIU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cliu assertion failed");

`endif

[hw/rtl/cliu_pkg.sv]
// Package with payload types, command record and code constants.
package cliu_pkg;

    localparam logic [2:0] KIND_WRITE     = 3'd0;
    localparam logic [2:0] KIND_INJ_START = 3'd1;
    localparam logic [2:0] KIND_INJ_LINE  = 3'd2;
    localparam logic [2:0] KIND_END       = 3'd3;
    localparam logic [2:0] KIND_UNKNOWN   = 3'd4;

    localparam logic [7:0] TYPE_BYTE   = 8'h00;
    localparam logic [7:0] TYPE_HALF   = 8'h02;
    localparam logic [7:0] TYPE_WORD   = 8'h04;
    localparam logic [7:0] TYPE_STRING = 8'h06;
    localparam logic [7:0] TYPE_INJECT = 8'hC2;
    localparam logic [7:0] TYPE_END    = 8'hF0;

    localparam logic [7:0] REGION_HIGH = 8'h80;

    typedef enum logic [2:0] {
        FMT_ZERO   = 3'd0,
        FMT_BYTE   = 3'd1,
        FMT_HALF   = 3'd2,
        FMT_WORD   = 3'd3,
        FMT_STRING = 3'd4,
        FMT_LINE   = 3'd5
    } t_fmt;

    typedef struct packed {
        logic [31:0] line_high;
        logic [31:0] line_low;
        logic        list_start;
    } t_in;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [31:0] target_address;
        logic [63:0] write_data;
        logic [3:0]  byte_count;
        logic        last_line;
        logic [7:0]  type_code;
        logic [31:0] line_number;
    } t_out;

    // Classified command passed from front to back through the queue.
    typedef struct packed {
        logic [2:0]  kind;
        t_fmt        fmt;
        logic [31:0] addr;
        logic [63:0] line;
        logic [3:0]  count;
        logic        last;
        logic [7:0]  type_code;
        logic [31:0] line_number;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

[hw/rtl/cliu_front.sv]
// Front end: accepts code lines, tracks list state and classifies each line.
module cliu_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  cliu_pkg::t_in   i_in_data,
    input  logic            i_full,
    output logic            o_push,
    output cliu_pkg::t_cmd  o_cmd
);
    import cliu_pkg::*;

    typedef enum logic [4:0] {
        MODE_WAIT   = 5'b00001,
        MODE_CODE   = 5'b00010,
        MODE_STRING = 5'b00100,
        MODE_INJECT = 5'b01000,
        MODE_ENDED  = 5'b10000
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_run, n_run;
    logic [31:0] r_line, n_line;

    logic        w_accept;
    logic [7:0]  w_type;
    logic [31:0] w_addr;
    logic [3:0]  w_take;
    logic [31:0] w_str_left;
    logic [31:0] w_inj_left;

    assign w_accept   = i_in_valid && !i_full;
    assign w_type     = i_in_data.line_high[31:24];
    assign w_addr     = {REGION_HIGH, i_in_data.line_high[23:0]};
    assign w_take     = (r_rem < 32'd8) ? r_rem[3:0] : 4'd8;
    assign w_str_left = r_rem - {28'd0, w_take};
    assign w_inj_left = r_rem - 32'd1;

    always_comb begin
        n_mode = r_mode;
        n_rem  = r_rem;
        n_run  = r_run;
        n_line = r_line;
        o_push = 1'b0;
        o_cmd             = '0;
        o_cmd.fmt         = FMT_ZERO;
        o_cmd.line        = {i_in_data.line_high, i_in_data.line_low};
        o_cmd.type_code   = w_type;
        o_cmd.line_number = r_line;
        if (w_accept) begin
            if (i_in_data.list_start) begin
                n_mode = MODE_CODE;
                n_rem  = '0;
                n_run  = '0;
                n_line = 32'd1;
            end else begin
                case (r_mode)
                    MODE_STRING: begin
                        n_line          = r_line + 32'd1;
                        o_push          = 1'b1;
                        o_cmd.kind      = KIND_WRITE;
                        o_cmd.fmt       = FMT_STRING;
                        o_cmd.addr      = r_run;
                        o_cmd.count     = w_take;
                        o_cmd.last      = (w_str_left == 32'd0);
                        o_cmd.type_code = TYPE_STRING;
                        n_rem           = w_str_left;
                        n_run           = r_run + 32'd8;
                        if (w_str_left == 32'd0) begin
                            n_mode = MODE_CODE;
                        end
                    end
                    MODE_INJECT: begin
                        n_line          = r_line + 32'd1;
                        o_push          = 1'b1;
                        o_cmd.kind      = KIND_INJ_LINE;
                        o_cmd.fmt       = FMT_LINE;
                        o_cmd.addr      = r_run;
                        o_cmd.last      = (w_inj_left == 32'd0);
                        o_cmd.type_code = TYPE_INJECT;
                        n_rem           = w_inj_left;
                        if (w_inj_left == 32'd0) begin
                            n_mode = MODE_CODE;
                        end
                    end
                    MODE_CODE: begin
                        n_line = r_line + 32'd1;
                        case (w_type)
                            TYPE_BYTE: begin
                                o_push      = 1'b1;
                                o_cmd.kind  = KIND_WRITE;
                                o_cmd.fmt   = FMT_BYTE;
                                o_cmd.addr  = w_addr;
                                o_cmd.count = 4'd1;
                            end
                            TYPE_HALF: begin
                                o_push      = 1'b1;
                                o_cmd.kind  = KIND_WRITE;
                                o_cmd.fmt   = FMT_HALF;
                                o_cmd.addr  = w_addr;
                                o_cmd.count = 4'd2;
                            end
                            TYPE_WORD: begin
                                o_push      = 1'b1;
                                o_cmd.kind  = KIND_WRITE;
                                o_cmd.fmt   = FMT_WORD;
                                o_cmd.addr  = w_addr;
                                o_cmd.count = 4'd4;
                            end
                            TYPE_STRING: begin
                                // string header: no result, arm the data run
                                if (i_in_data.line_low != 32'd0) begin
                                    n_mode = MODE_STRING;
                                    n_rem  = i_in_data.line_low;
                                    n_run  = w_addr;
                                end
                            end
                            TYPE_INJECT: begin
                                o_push     = 1'b1;
                                o_cmd.kind = KIND_INJ_START;
                                o_cmd.addr = w_addr;
                                o_cmd.last = (i_in_data.line_low == 32'd0);
                                if (i_in_data.line_low != 32'd0) begin
                                    n_mode = MODE_INJECT;
                                    n_rem  = i_in_data.line_low;
                                    n_run  = w_addr;
                                end
                            end
                            TYPE_END: begin
                                o_push     = 1'b1;
                                o_cmd.kind = KIND_END;
                                n_mode     = MODE_ENDED;
                            end
                            default: begin
                                o_push     = 1'b1;
                                o_cmd.kind = KIND_UNKNOWN;
                            end
                        endcase
                    end
                    default: begin
                        // waiting or ended: drop the line
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_WAIT;
            r_rem  <= '0;
            r_run  <= '0;
            r_line <= '0;
        end else begin
            r_mode <= n_mode;
            r_rem  <= n_rem;
            r_run  <= n_run;
            r_line <= n_line;
        end
    end

endmodule

[hw/rtl/cliu_fifo.sv]
// Short command queue between the front and back ends.
module cliu_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  cliu_pkg::t_cmd        i_cmd,
    input  logic                  i_pop,
    output cliu_pkg::t_cmd        o_head,
    output cliu_pkg::t_queue_status o_status
);
    import cliu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    logic w_push;
    logic w_pop;

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_head = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[hw/rtl/cliu_back.sv]
// Back end: formats queued commands into result transactions.
module cliu_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  cliu_pkg::t_cmd          i_head,
    input  cliu_pkg::t_queue_status i_status,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output cliu_pkg::t_out          o_out_data
);
    import cliu_pkg::*;

    logic        r_valid, n_valid;
    t_out        r_out;
    logic [63:0] w_data;
    logic [63:0] w_str_data;

    assign o_pop = !i_status.empty && (!r_valid || !i_out_stall);

    // keep only the first count bytes of a string data line
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_str_data[63-8*i -: 8] = (4'(i) < i_head.count) ?
                i_head.line[63-8*i -: 8] : 8'd0;
        end
    end

    always_comb begin
        case (i_head.fmt)
            FMT_BYTE:   w_data = {i_head.line[7:0], 56'd0};
            FMT_HALF:   w_data = {i_head.line[15:0], 48'd0};
            FMT_WORD:   w_data = {i_head.line[31:0], 32'd0};
            FMT_STRING: w_data = w_str_data;
            FMT_LINE:   w_data = i_head.line;
            default:    w_data = 64'd0;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.result_kind    <= i_head.kind;
            r_out.target_address <= i_head.addr;
            r_out.write_data     <= w_data;
            r_out.byte_count     <= i_head.count;
            r_out.last_line      <= i_head.last;
            r_out.type_code      <= i_head.type_code;
            r_out.line_number    <= i_head.line_number;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

endmodule

[hw/rtl/code_list_write_interpreter_unit.sv]
// Top level of the code list write interpreter: front, queue and back end.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------
//  in      | input     | i_in_valid / o_in_stall | i_in_data  (t_in)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (t_out)
//
// One code line is accepted per cycle while the queue is not full; the
// front end's state registers take each line's update as it is accepted.
// A result is written into the queue at the edge that accepts its line,
// then popped into the back end output register, which a stalled, full
// output register delays. Lines that cause no result only update the front state.
// Reset is synchronous and active low; it returns the front end to
// waiting for a list header and empties the queue and output register.
// o_in_stall rises only while the QUEUE_DEPTH-entry queue is full, so a
// stalled output keeps taking lines until the queue fills.
module code_list_write_interpreter_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  cliu_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output cliu_pkg::t_out o_out_data
);
    import cliu_pkg::*;
`include "code_list_write_interpreter_unit_assert.svh"

    logic          w_push;
    logic          w_pop;
    t_cmd          w_cmd;
    t_cmd          w_head;
    t_queue_status w_status;

    // Stall the input only on a full queue; hold lines that emit nothing too.
    assign o_in_stall = w_status.full;

    cliu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_full     (w_status.full),
        .o_push     (w_push),
        .o_cmd      (w_cmd)
    );

    cliu_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_cmd),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_status)
    );

    cliu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_status    (w_status),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // The front end never pushes into a full queue.
    `CLIU_ASSERT_NOW(a_no_overflow, w_push, !w_status.full)
    // The back end never pops an empty queue.
    `CLIU_ASSERT_NOW(a_no_underflow, w_pop, !w_status.empty)
    // A pop always loads the output register.
    `CLIU_ASSERT_NEXT(a_pop_loads_output, w_pop, o_out_valid)
    // Memory writes carry one to eight bytes; other results carry none.
    `CLIU_ASSERT_NOW(a_write_count,
        o_out_valid && (o_out_data.result_kind == KIND_WRITE),
        (o_out_data.byte_count != 4'd0) && (o_out_data.byte_count <= 4'd8))

endmodule

[tb/tb_code_list_write_interpreter_unit.sv]
// Self-checking testbench for the code list write interpreter unit.
module tb_code_list_write_interpreter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import cliu_pkg::*;

    // Stop the stimulus once this many interpreted lines have gone in.
    localparam int LINE_TARGET = 1850;
    // Final stretch of the run with no idling on either side.
    localparam int CALM_LINES  = 250;
    // Long receiver hold-off, long enough to fill the internal queue.
    localparam int HOLD_CYCLES = 80;
    // Abort point for a run that hangs; far above the slowest legal run.
    localparam int CYCLE_LIMIT = 400000;
    localparam int DIR_ROWS    = 25;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    t_in  in_data;
    logic out_valid;
    logic out_stall;
    t_out out_data;

    code_list_write_interpreter_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Line decoder model: mirrors the parser state of the block.
    // ------------------------------------------------------------------
    typedef enum logic [4:0] {
        LIST_WAIT   = 5'b00001,
        LIST_CODE   = 5'b00010,
        LIST_STRING = 5'b00100,
        LIST_INJECT = 5'b01000,
        LIST_ENDED  = 5'b10000
    } t_list_mode;

    t_list_mode  list_mode  = LIST_WAIT;
    logic [31:0] run_left   = '0;   // string bytes or inject lines still due
    logic [31:0] run_addr   = '0;   // next string address or inject address
    logic [31:0] line_idx   = '0;   // index of the next line in the list

    // Expected results, oldest first.
    t_out pending_results [$];

    int  fail_count   = 0;
    int  lines_sent   = 0;
    int  cycle_count  = 0;
    bit  calm         = 1'b0;
    bit  hold_request = 1'b0;
    int  hold_left    = 0;

    // Decode one accepted line; return 1 and the result when it makes one.
    function automatic bit decode_line(input t_in l, output t_out r);
        logic [7:0]  ty;
        logic [31:0] tgt;
        logic [63:0] full;
        logic [63:0] keep;
        logic [31:0] take;
        logic [31:0] ln;
        ty   = l.line_high[31:24];
        tgt  = {REGION_HIGH, l.line_high[23:0]};
        full = {l.line_high, l.line_low};
        ln   = line_idx;
        r    = '0;

        // A header restarts the list from any state and is skipped itself.
        if (l.list_start) begin
            list_mode = LIST_CODE;
            run_left  = '0;
            run_addr  = '0;
            line_idx  = 32'd1;
            return 1'b0;
        end
        if (list_mode == LIST_WAIT || list_mode == LIST_ENDED) begin
            return 1'b0;
        end

        line_idx      = ln + 32'd1;
        r.line_number = ln;

        if (list_mode == LIST_STRING) begin
            // Keep only the leading bytes still due; zero the tail.
            take = (run_left < 32'd8) ? run_left : 32'd8;
            keep = ~(64'hFFFF_FFFF_FFFF_FFFF >> (8 * take));
            run_left         = run_left - take;
            r.result_kind    = KIND_WRITE;
            r.target_address = run_addr;
            r.write_data     = full & keep;
            r.byte_count     = take[3:0];
            r.last_line      = (run_left == '0);
            r.type_code      = TYPE_STRING;
            run_addr         = run_addr + 32'd8;
            if (run_left == '0) begin
                list_mode = LIST_CODE;
            end
            return 1'b1;
        end
        if (list_mode == LIST_INJECT) begin
            // Inject body lines pass through whole, whatever their type byte.
            run_left         = run_left - 32'd1;
            r.result_kind    = KIND_INJ_LINE;
            r.target_address = run_addr;
            r.write_data     = full;
            r.last_line      = (run_left == '0);
            r.type_code      = TYPE_INJECT;
            if (run_left == '0) begin
                list_mode = LIST_CODE;
            end
            return 1'b1;
        end

        r.type_code = ty;
        case (ty)
            TYPE_BYTE: begin
                r.result_kind    = KIND_WRITE;
                r.target_address = tgt;
                r.write_data     = {l.line_low[7:0], 56'd0};
                r.byte_count     = 4'd1;
            end
            TYPE_HALF: begin
                r.result_kind    = KIND_WRITE;
                r.target_address = tgt;
                r.write_data     = {l.line_low[15:0], 48'd0};
                r.byte_count     = 4'd2;
            end
            TYPE_WORD: begin
                r.result_kind    = KIND_WRITE;
                r.target_address = tgt;
                r.write_data     = {l.line_low, 32'd0};
                r.byte_count     = 4'd4;
            end
            TYPE_STRING: begin
                // The string header itself writes nothing.
                if (l.line_low != '0) begin
                    list_mode = LIST_STRING;
                    run_left  = l.line_low;
                    run_addr  = tgt;
                end
                return 1'b0;
            end
            TYPE_INJECT: begin
                r.result_kind    = KIND_INJ_START;
                r.target_address = tgt;
                r.last_line      = (l.line_low == '0);
                if (l.line_low != '0) begin
                    list_mode = LIST_INJECT;
                    run_left  = l.line_low;
                    run_addr  = tgt;
                end
            end
            TYPE_END: begin
                r.result_kind = KIND_END;
                list_mode     = LIST_ENDED;
            end
            default: begin
                r.result_kind = KIND_UNKNOWN;
            end
        endcase
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Directed lines. Where the result is obvious it is typed in here;
    // rows marked EXP_PREDICTED go through the decoder model instead.
    // ------------------------------------------------------------------
    typedef enum {EXP_NONE, EXP_TYPED, EXP_PREDICTED} t_dir_check;

    typedef struct {
        logic [31:0] hi;
        logic [31:0] lo;
        bit          start;
        t_dir_check  chk;
        t_out        res;
    } t_dir_row;

    t_dir_row dir_table [DIR_ROWS] = '{
        // no list open yet: ignored
        '{32'h0012_3456, 32'h0000_0000, 1'b0, EXP_NONE, '0},
        // header with every payload bit set
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, EXP_NONE, '0},
        '{32'h00FF_FFFF, 32'hFFFF_FFAB, 1'b0, EXP_TYPED,
          '{KIND_WRITE, 32'h80FF_FFFF, 64'hAB00_0000_0000_0000, 4'd1, 1'b0,
            TYPE_BYTE, 32'd1}},
        '{32'h0200_0000, 32'h0000_BEEF, 1'b0, EXP_TYPED,
          '{KIND_WRITE, 32'h8000_0000, 64'hBEEF_0000_0000_0000, 4'd2, 1'b0,
            TYPE_HALF, 32'd2}},
        '{32'h04AB_CDEF, 32'hFFFF_FFFF, 1'b0, EXP_TYPED,
          '{KIND_WRITE, 32'h80AB_CDEF, 64'hFFFF_FFFF_0000_0000, 4'd4, 1'b0,
            TYPE_WORD, 32'd3}},
        // empty string: nothing follows
        '{32'h0600_0010, 32'h0000_0000, 1'b0, EXP_NONE, '0},
        // 11-byte string crossing into the next 16 MB page
        '{32'h06FF_FFF8, 32'h0000_000B, 1'b0, EXP_NONE, '0},
        '{32'h0102_0304, 32'h0506_0708, 1'b0, EXP_PREDICTED, '0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, EXP_PREDICTED, '0},
        '{32'hFF00_0000, 32'h0000_0000, 1'b0, EXP_TYPED,
          '{KIND_UNKNOWN, 32'd0, 64'd0, 4'd0, 1'b0, 8'hFF, 32'd8}},
        // inject with no body
        '{32'hC200_1234, 32'h0000_0000, 1'b0, EXP_TYPED,
          '{KIND_INJ_START, 32'h8000_1234, 64'd0, 4'd0, 1'b1, TYPE_INJECT, 32'd9}},
        '{32'hC2FF_FFFF, 32'h0000_0002, 1'b0, EXP_PREDICTED, '0},
        '{32'hDEAD_BEEF, 32'h0BAD_F00D, 1'b0, EXP_PREDICTED, '0},
        // end-of-list type inside an inject body is plain code
        '{32'hF000_0000, 32'h0000_0000, 1'b0, EXP_PREDICTED, '0},
        // inject cut short by a new header
        '{32'hC200_0100, 32'h0000_0005, 1'b0, EXP_PREDICTED, '0},
        '{32'h1234_5678, 32'h9ABC_DEF0, 1'b0, EXP_PREDICTED, '0},
        '{32'h0000_0000, 32'h0000_0000, 1'b1, EXP_NONE, '0},
        // maximum string length, cut short by a new header
        '{32'h0600_0000, 32'hFFFF_FFFF, 1'b0, EXP_NONE, '0},
        '{32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, EXP_PREDICTED, '0},
        '{32'h0000_0000, 32'h0000_0000, 1'b1, EXP_NONE, '0},
        '{32'hF000_0000, 32'h0000_0000, 1'b0, EXP_TYPED,
          '{KIND_END, 32'd0, 64'd0, 4'd0, 1'b0, TYPE_END, 32'd1}},
        // after the end: ignored
        '{32'h0400_0000, 32'h1234_5678, 1'b0, EXP_NONE, '0},
        '{32'h0000_0000, 32'h0000_0000, 1'b1, EXP_NONE, '0},
        '{32'hC200_0000, 32'hFFFF_FFFF, 1'b0, EXP_PREDICTED, '0},
        '{32'h55AA_55AA, 32'hAA55_AA55, 1'b0, EXP_PREDICTED, '0}
    };

    // ------------------------------------------------------------------
    // Sender side. Called at a falling edge; returns at a falling edge
    // with valid left high unless an idle gap was inserted.
    // ------------------------------------------------------------------
    task automatic offer_line(input t_in l, input bit typed, input bit typed_has,
                              input t_out typed_res);
        t_out res;
        bit   has;
        bit   live;
        in_valid <= 1'b1;
        in_data  <= l;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        // Count only lines the parser actually looks at.
        live = l.list_start || list_mode == LIST_CODE || list_mode == LIST_STRING ||
               list_mode == LIST_INJECT;
        has = decode_line(l, res);
        if (typed) begin
            if (typed_has) pending_results.push_back(typed_res);
        end else if (has) begin
            pending_results.push_back(res);
        end
        if (live) lines_sent++;
        @(negedge clk);
        // Insert an idle burst now and then; none while the receiver holds.
        if (!calm && hold_left == 0 && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
    endtask

    task automatic send(input logic [31:0] hi, input logic [31:0] lo, input bit start);
        t_in l;
        l.line_high  = hi;
        l.line_low   = lo;
        l.list_start = start;
        offer_line(l, 1'b0, 1'b0, '0);
    endtask

    // One random code list: mostly well-formed commands with random content,
    // some runs cut short by the next header, some lists closed by an end.
    task automatic random_list();
        int          ncmd;
        int          sel;
        int          n;
        logic [7:0]  run_type;
        send($urandom, $urandom, 1'b1);
        ncmd = $urandom_range(1, 12);
        for (int c = 0; c < ncmd; c++) begin
            sel = $urandom_range(0, 99);
            if (sel < 15) begin
                send({TYPE_BYTE, 24'($urandom)}, $urandom, 1'b0);
            end else if (sel < 30) begin
                send({TYPE_HALF, 24'($urandom)}, $urandom, 1'b0);
            end else if (sel < 45) begin
                send({TYPE_WORD, 24'($urandom)}, $urandom, 1'b0);
            end else if (sel < 62) begin
                n = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 40);
                send({TYPE_STRING, 24'($urandom)}, 32'(n), 1'b0);
                for (int k = 0; k < (n + 7) / 8; k++) send($urandom, $urandom, 1'b0);
            end else if (sel < 77) begin
                n = $urandom_range(0, 6);
                send({TYPE_INJECT, 24'($urandom)}, 32'(n), 1'b0);
                for (int k = 0; k < n; k++) send($urandom, $urandom, 1'b0);
            end else if (sel < 85) begin
                // arbitrary type byte, mostly unknown types
                send($urandom, $urandom, 1'b0);
            end else if (sel < 93) begin
                // long run left open; the next header aborts it
                run_type = $urandom_range(0, 1) ? TYPE_STRING : TYPE_INJECT;
                send({run_type, 24'($urandom)}, $urandom | 32'h40, 1'b0);
                repeat ($urandom_range(1, 3)) send($urandom, $urandom, 1'b0);
                return;
            end else begin
                // end the list, then a few lines that must be ignored
                send({TYPE_END, 24'($urandom)}, $urandom, 1'b0);
                repeat ($urandom_range(0, 3)) send($urandom, $urandom, 1'b0);
                return;
            end
        end
        if ($urandom_range(0, 1)) send({TYPE_END, 24'($urandom)}, $urandom, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, random lists, drain, verdict.
    // ------------------------------------------------------------------
    initial begin
        t_in l;
        int  list_no;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            l.line_high  = dir_table[i].hi;
            l.line_low   = dir_table[i].lo;
            l.list_start = dir_table[i].start;
            offer_line(l, dir_table[i].chk != EXP_PREDICTED, dir_table[i].chk == EXP_TYPED,
                       dir_table[i].res);
        end

        list_no = 0;
        while (lines_sent < LINE_TARGET) begin
            if (lines_sent >= LINE_TARGET - CALM_LINES) calm = 1'b1;
            // Hold the receiver off while lines keep coming in.
            if (list_no == 8) hold_request = 1'b1;
            // Pause the sender until every outstanding result has arrived.
            if (list_no == 16) begin
                in_valid <= 1'b0;
                do @(negedge clk); while (pending_results.size() != 0);
            end
            // Stray lines between lists.
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3)) send($urandom, $urandom, 1'b0);
            end
            random_list();
            list_no++;
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        // Keep clocking after the last expected result so strays still show up.
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("code_list_write_interpreter_unit regression: pass");
        end else begin
            $display("code_list_write_interpreter_unit regression: fail");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver side: random stall bursts plus one long hold-off.
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left = 0;
        out_stall  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 11) - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking.
    // ------------------------------------------------------------------
    function automatic void check_field(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", field, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk) begin
        t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with none expected: kind %0d, line %0d",
                       out_data.result_kind, out_data.line_number);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("result_kind", want.result_kind, out_data.result_kind);
                check_field("target_address", want.target_address, out_data.target_address);
                check_field("write_data", want.write_data, out_data.write_data);
                check_field("byte_count", want.byte_count, out_data.byte_count);
                check_field("last_line", want.last_line, out_data.last_line);
                check_field("type_code", want.type_code, out_data.type_code);
                check_field("line_number", want.line_number, out_data.line_number);
            end
        end
    end

    // Drop the run if it hangs.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("code_list_write_interpreter_unit regression: fail");
            $finish;
        end
    end

endmodule
